// ===== sv/ibrm_pkg.sv =====
// ----------------------------------------------------------------------------
// IPv4 ban rule matcher - shared package
// Rule table sizes, operation and rule kind codes, queue entry types and the
// single-rule coverage test.
// ----------------------------------------------------------------------------
package ibrm_pkg;

  // table geometry
  localparam int RULES  = 64;
  localparam int IDX_W  = $clog2(RULES);
  localparam int CNT_W  = $clog2(RULES + 1);
  localparam int HELD_W = 7;

  // command queue between front and back
  localparam int FQ_DEPTH = 2;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

  // func field codes
  localparam logic [1:0] FN_CHECK  = 2'd0;
  localparam logic [1:0] FN_INSERT = 2'd1;
  localparam logic [1:0] FN_CLEAR  = 2'd2;

  // rule kind codes
  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_WILD  = 2'd1;
  localparam logic [1:0] KIND_RANGE = 2'd2;

  // classified operation
  typedef enum logic [1:0] {
    OP_CHECK  = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // one stored rule
  typedef struct packed {
    logic [3:0]  wild;
    logic [1:0]  kind;
    logic [31:0] base;
    logic [31:0] tail;
  } rule_t;

  // one queued command; a check carries its address in rule.base
  typedef struct packed {
    op_t   op;
    rule_t rule;
  } cmd_t;

  // does rule r cover address a
  function automatic logic rule_covers(rule_t r, logic [31:0] a);
    logic hit;
    hit = 1'b0;
    case (r.kind)
      KIND_EXACT: hit = (r.base == a);
      KIND_WILD: begin
        hit = 1'b1;
        for (int i = 0; i < 4; i++) begin
          // octet 0 is the first dotted octet (bits 31..24)
          if (!r.wild[i] && (r.base[31-8*i -: 8] != a[31-8*i -: 8])) begin
            hit = 1'b0;
          end
        end
      end
      KIND_RANGE: hit = (a >= r.base) && (a <= r.tail);
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

// ===== sv/ibrm_front.sv =====
// ----------------------------------------------------------------------------
// IPv4 ban rule matcher - front end
// Accepts input items, classifies the operation and packs the rule into a
// command for the queue.
// ----------------------------------------------------------------------------
module ibrm_front (
  input  logic              push,
  input  logic [1:0]        func,
  input  logic [31:0]       address,
  input  logic [1:0]        rule_kind,
  input  logic [3:0]        octet_wild,
  input  logic [31:0]       range_end,
  input  logic              q_full,
  output logic              q_wr,
  output ibrm_pkg::cmd_t    q_cmd
);
  import ibrm_pkg::*;

  // transfer when the queue has room
  assign q_wr = push && !q_full;

  // classify operation
  always_comb begin
    case (func)
      FN_CHECK:  q_cmd.op = OP_CHECK;
      FN_INSERT: q_cmd.op = OP_INSERT;
      FN_CLEAR:  q_cmd.op = OP_CLEAR;
      default:   q_cmd.op = OP_NOP;
    endcase
    q_cmd.rule.wild = octet_wild;
    q_cmd.rule.kind = rule_kind;
    q_cmd.rule.base = address;
    q_cmd.rule.tail = range_end;
  end

endmodule

// ===== sv/ibrm_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// IPv4 ban rule matcher - command queue
// Short queue that decouples the front end from the table engine.
// ----------------------------------------------------------------------------
module ibrm_cmd_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  ibrm_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd,
  output ibrm_pkg::cmd_t rd_cmd,
  output logic           empty
);
  import ibrm_pkg::*;

  cmd_t                slot [FQ_DEPTH];
  logic [FQ_PTR_W-1:0] wr_ptr;
  logic [FQ_PTR_W-1:0] rd_ptr;
  logic [FQ_CNT_W-1:0] fill;

  assign full   = (fill == FQ_CNT_W'(FQ_DEPTH));
  assign empty  = (fill == '0);
  assign rd_cmd = slot[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr) begin
      slot[wr_ptr] <= wr_cmd;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({wr, rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/ibrm_back.sv =====
// ----------------------------------------------------------------------------
// IPv4 ban rule matcher - table engine
// Holds the rule table, executes insert and clear, walks the table one rule
// per cycle for a check, and keeps the result register.
// ----------------------------------------------------------------------------
module ibrm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  ibrm_pkg::cmd_t    q_cmd,
  output logic              q_rd,
  output logic              empty,
  input  logic              pop,
  output logic              matched,
  output logic              status,
  output logic [6:0]        rules_held
);
  import ibrm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t            state;
  rule_t             table_mem [RULES];
  rule_t             rd_rule;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  iss;
  logic              pipe_vld;
  logic [31:0]       chk_addr;
  logic              out_valid;
  logic              tbl_full;
  logic              start;
  logic              mem_we;
  logic              hit;
  logic              scan_done;

  assign empty    = !out_valid;
  assign tbl_full = (cnt == CNT_W'(RULES));
  assign start    = (state == ST_IDLE) && !q_empty && !out_valid;
  assign q_rd     = start;
  assign mem_we   = start && (q_cmd.op == OP_INSERT) && !tbl_full;
  assign hit      = pipe_vld && rule_covers(rd_rule, chk_addr);
  assign scan_done = hit || (!pipe_vld && (iss == cnt));

  // rule table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[cnt[IDX_W-1:0]] <= q_cmd.rule;
    end
    rd_rule <= table_mem[iss[IDX_W-1:0]];
  end

  // check address
  always_ff @(posedge clk) begin
    if (start) begin
      chk_addr <= q_cmd.rule.base;
    end
  end

  // sequencer, count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      iss        <= '0;
      pipe_vld   <= 1'b0;
      out_valid  <= 1'b0;
      matched    <= 1'b0;
      status     <= 1'b0;
      rules_held <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            matched <= 1'b0;
            status  <= 1'b0;
            case (q_cmd.op)
              OP_CHECK: begin
                iss      <= '0;
                pipe_vld <= 1'b0;
                state    <= ST_SCAN;
              end
              OP_INSERT: begin
                out_valid <= 1'b1;
                if (tbl_full) begin
                  status     <= 1'b1;
                  rules_held <= HELD_W'(cnt);
                end else begin
                  cnt        <= cnt + 1'b1;
                  rules_held <= HELD_W'(cnt + 1'b1);
                end
              end
              OP_CLEAR: begin
                cnt        <= '0;
                rules_held <= '0;
                out_valid  <= 1'b1;
              end
              default: begin
                rules_held <= HELD_W'(cnt);
                out_valid  <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            matched    <= hit;
            rules_held <= HELD_W'(cnt);
            out_valid  <= 1'b1;
            pipe_vld   <= 1'b0;
            state      <= ST_IDLE;
          end else if (iss != cnt) begin
            // issue next table read, compare arrives next cycle
            iss      <= iss + 1'b1;
            pipe_vld <= 1'b1;
          end else begin
            pipe_vld <= 1'b0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/ipv4_ban_rule_matcher.sv =====
// ----------------------------------------------------------------------------
// IPv4 ban rule matcher - top level
// Table of up to 64 IPv4 ban rules (exact, octet wildcard, inclusive range)
// with check, insert and clear operations.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive func, address, rule_kind, octet_wild and range_end
//   with push; a transfer happens on a clock edge with push high and full low.
//   Result queue: matched, status and rules_held are valid while empty is
//   low; a transfer happens on a clock edge with pop high and empty low.
//   Every item gives exactly one result, in order.
// Timing:
//   Items pass a two-entry command queue to the table engine. Insert, clear
//   and unused codes finish without a table walk. A check walks the rule
//   table one stored rule per cycle through the table's registered read
//   port and stops early on a hit.
// Reset and stall:
//   rst (synchronous, active high) empties the table and both queues.
//   While a result is not popped the engine holds, and the command queue
//   keeps taking items until it is full.
// ----------------------------------------------------------------------------
module ipv4_ban_rule_matcher (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [31:0] address,
  input  logic [1:0]  rule_kind,
  input  logic [3:0]  octet_wild,
  input  logic [31:0] range_end,
  output logic        empty,
  input  logic        pop,
  output logic        matched,
  output logic        status,
  output logic [6:0]  rules_held
);
  import ibrm_pkg::*;

  logic q_wr;
  logic q_rd;
  logic q_empty;
  cmd_t wr_cmd;
  cmd_t rd_cmd;

  ibrm_front u_front (
    .push       (push),
    .func       (func),
    .address    (address),
    .rule_kind  (rule_kind),
    .octet_wild (octet_wild),
    .range_end  (range_end),
    .q_full     (full),
    .q_wr       (q_wr),
    .q_cmd      (wr_cmd)
  );

  ibrm_cmd_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wr_cmd (wr_cmd),
    .full   (full),
    .rd     (q_rd),
    .rd_cmd (rd_cmd),
    .empty  (q_empty)
  );

  ibrm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_cmd      (rd_cmd),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .matched    (matched),
    .status     (status),
    .rules_held (rules_held)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPv4 ban rule matcher - testbench
// Drives check, insert, clear and spare-code items through the input queue
// with random gaps and pops results with random stalls. A scoreboard keeps
// its own copy of the rule table, predicts matched, status and rules_held
// for every accepted item, and compares each popped result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ibrm_pkg::*;

  // codes with no name in the package
  localparam logic [1:0] FN_SPARE     = 2'd3;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam int ITEMS    = 1200;
  localparam int MAX_GAP  = 12;
  localparam int SHOW_MAX = 10;

  // expected result of one item
  typedef struct packed {
    logic       matched;
    logic       status;
    logic [6:0] held;
  } verdict_t;

  // rule as sent, kept to aim checks at it
  typedef struct {
    logic [1:0]  kind;
    logic [3:0]  wild;
    logic [31:0] lo;
    logic [31:0] hi;
  } sent_rule_t;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow rule table and queue of expected verdicts
  // --------------------------------------------------------------------------
  class ban_table_sb;
    logic [1:0]  kind_of [RULES];
    logic [3:0]  wild_of [RULES];
    logic [31:0] low_of  [RULES];
    logic [31:0] high_of [RULES];
    int unsigned stored;
    verdict_t    due[$];
    int unsigned errors;

    function new();
      stored = 0;
      errors = 0;
    endfunction

    // wildcard octets drop out of the compare mask; octet 0 is bits 31..24
    function bit covers(int idx, logic [31:0] a);
      logic [31:0] care;
      care = {{8{!wild_of[idx][0]}}, {8{!wild_of[idx][1]}},
              {8{!wild_of[idx][2]}}, {8{!wild_of[idx][3]}}};
      case (kind_of[idx])
        KIND_EXACT: return a == low_of[idx];
        KIND_WILD:  return ((a ^ low_of[idx]) & care) == 32'd0;
        KIND_RANGE: return (a >= low_of[idx]) && (a <= high_of[idx]);
        default:    return 1'b0;
      endcase
    endfunction

    // item accepted by the block: update shadow table, queue the verdict
    function void note_item(logic [1:0] f, logic [31:0] a, logic [1:0] k,
                            logic [3:0] w, logic [31:0] e);
      verdict_t v;
      v = '0;
      case (f)
        FN_CHECK: begin
          for (int i = 0; i < stored; i++) begin
            if (covers(i, a)) v.matched = 1'b1;
          end
        end
        FN_INSERT: begin
          if (stored >= RULES) begin
            v.status = 1'b1;
          end else begin
            kind_of[stored] = k;
            wild_of[stored] = w;
            low_of[stored]  = a;
            high_of[stored] = e;
            stored++;
          end
        end
        FN_CLEAR: stored = 0;
        default: ;
      endcase
      v.held = 7'(stored);
      due.push_back(v);
    endfunction

    // result popped from the block: compare with the oldest verdict
    function void check_result(logic m, logic s, logic [6:0] h);
      verdict_t v;
      if (due.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: unexpected result matched=%0d status=%0d held=%0d",
                   $realtime, m, s, h);
        return;
      end
      v = due.pop_front();
      if (v.matched !== m || v.status !== s || v.held !== h) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("%0t: exp matched=%0d status=%0d held=%0d, got %0d %0d %0d",
                   $realtime, v.matched, v.status, v.held, m, s, h);
      end
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        push       = 1'b0;
  logic        pop        = 1'b0;
  logic [1:0]  func       = '0;
  logic [31:0] address    = '0;
  logic [1:0]  rule_kind  = '0;
  logic [3:0]  octet_wild = '0;
  logic [31:0] range_end  = '0;
  logic        full;
  logic        empty;
  logic        matched;
  logic        status;
  logic [6:0]  rules_held;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ipv4_ban_rule_matcher i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .func       (func),
    .address    (address),
    .rule_kind  (rule_kind),
    .octet_wild (octet_wild),
    .range_end  (range_end),
    .empty      (empty),
    .pop        (pop),
    .matched    (matched),
    .status     (status),
    .rules_held (rules_held)
  );

  ban_table_sb sb;
  sent_rule_t  recent[$];
  int unsigned sent      = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  function automatic int draw_gap(bit calm);
    return calm ? 0 : int'($urandom_range(0, MAX_GAP));
  endfunction

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // one transfer into the input queue, after a random gap
  task automatic send_item(logic [1:0] f, logic [31:0] a, logic [1:0] k,
                           logic [3:0] w, logic [31:0] e);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    func       <= f;
    address    <= a;
    rule_kind  <= k;
    octet_wild <= w;
    range_end  <= e;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(f, a, k, w, e);
    sent++;
    if (f == FN_CLEAR) recent.delete();
  endtask

  // check item; the rule fields are don't-care and carry noise
  task automatic send_check(logic [31:0] a);
    send_item(FN_CHECK, a, 2'($urandom), 4'($urandom), $urandom);
  endtask

  task automatic send_rule(logic [1:0] k, logic [31:0] lo, logic [3:0] w,
                           logic [31:0] hi);
    sent_rule_t r;
    r.kind = k;
    r.wild = w;
    r.lo   = lo;
    r.hi   = hi;
    recent.push_back(r);
    if (recent.size() > RULES) void'(recent.pop_front());
    send_item(FN_INSERT, lo, k, w, hi);
  endtask

  // random rule, unknown kind less often; wide spans may wrap below start
  task automatic send_random_rule();
    logic [1:0]  k;
    logic [31:0] lo;
    logic [31:0] hi;
    int          pick;
    pick = $urandom_range(0, 9);
    k  = (pick < 3) ? KIND_EXACT : (pick < 6) ? KIND_WILD :
         (pick < 9) ? KIND_RANGE : KIND_UNKNOWN;
    lo = $urandom;
    hi = (k == KIND_RANGE) ? lo + ($urandom >> $urandom_range(0, 31)) : $urandom;
    send_rule(k, lo, 4'($urandom), hi);
  endtask

  // address aimed at a recently sent rule: edges, inside, or just off
  function automatic logic [31:0] probe_addr();
    sent_rule_t  r;
    logic [31:0] a;
    int          i;
    if (recent.size() == 0 || $urandom_range(0, 7) == 0) return $urandom;
    r = recent[$urandom_range(0, recent.size() - 1)];
    a = r.lo;
    if (r.kind == KIND_RANGE) begin
      case ($urandom_range(0, 4))
        0: a = r.lo;
        1: a = r.hi;
        2: a = r.lo - 32'd1;
        3: a = r.hi + 32'd1;
        default: a = $urandom_range(r.lo, r.hi);
      endcase
    end else begin
      if (r.kind == KIND_WILD) begin
        for (i = 0; i < 4; i++) begin
          if (r.wild[i]) a[31-8*i -: 8] = 8'($urandom);
        end
      end
      if ($urandom_range(0, 3) == 0) a = a ^ (32'd1 << $urandom_range(0, 31));
    end
    return a;
  endfunction

  // hold off the sender until every expected result has come back
  task automatic drain();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int  scen;
    bit  mid_done;
    mid_done = 1'b0;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, spare code, every kind with its edges
    send_check(32'h0000_0000);
    send_item(FN_SPARE, $urandom, 2'($urandom), 4'($urandom), $urandom);
    send_rule(KIND_EXACT,   32'hFFFF_FFFF, 4'h0,    32'h0000_0000);
    send_rule(KIND_EXACT,   32'h0000_0000, 4'hF,    32'hFFFF_FFFF);
    send_rule(KIND_WILD,    32'h0A14_1E28, 4'b1000, 32'h0000_0000);
    send_rule(KIND_WILD,    32'hC001_0203, 4'b0001, 32'h0000_0000);
    send_rule(KIND_RANGE,   32'h8000_0000, 4'hF,    32'h8000_FFFF);
    send_rule(KIND_RANGE,   32'h9000_0000, 4'h0,    32'h8FFF_FFFF);
    send_rule(KIND_UNKNOWN, 32'h1234_5678, 4'hF,    32'hFFFF_FFFF);
    send_check(32'hFFFF_FFFF);
    send_check(32'h0000_0000);
    send_check(32'h0A14_1EFF);
    send_check(32'h0A14_1F28);
    send_check(32'h7F01_0203);
    send_check(32'hC001_0204);
    send_check(32'h8000_0000);
    send_check(32'h8000_FFFF);
    send_check(32'h7FFF_FFFF);
    send_check(32'h8001_0000);
    send_check(32'h9000_0000);
    send_check(32'h1234_5678);
    send_item(FN_CLEAR, $urandom, 2'($urandom), 4'($urandom), $urandom);
    send_check(32'hFFFF_FFFF);
    send_rule(KIND_WILD, 32'h0000_0000, 4'hF, 32'h0000_0000);
    send_check(32'h5A5A_5A5A);
    drain();

    // random sessions: rules then checks aimed at them, some fills and noise
    while (sent < ITEMS) begin
      if (!mid_done && sent >= ITEMS / 2) begin
        drain();
        mid_done = 1'b1;
      end
      scen = $urandom_range(0, 19);
      if (scen < 15) begin
        if ($urandom_range(0, 2) == 0)
          send_item(FN_CLEAR, $urandom, 2'($urandom), 4'($urandom), $urandom);
        repeat ($urandom_range(1, 8)) send_random_rule();
        repeat ($urandom_range(1, 12)) send_check(probe_addr());
      end else if (scen == 15) begin
        // insert a long run of rules, which can run the table past full
        repeat ($urandom_range(60, 70)) send_random_rule();
        repeat ($urandom_range(2, 5)) send_check(probe_addr());
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(2'($urandom), $urandom, 2'($urandom), 4'($urandom), $urandom);
      end
      if ($urandom_range(0, 7) == 0) send_calm = ~send_calm;
    end

    // wind down and report
    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Result side: pop with random stalls, check every transfer
  // --------------------------------------------------------------------------
  initial begin : result_side
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(recv_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      sb.check_result(matched, status, rules_held);
      if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
    end
  end

  // hang guard
  initial begin : watchdog
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
